FILE: rtl/wpc_pkg.sv
package wpc_pkg;

	localparam int ROUNDS = 10;
	localparam int WORDS = 8;
	localparam int QDEPTH = 2;

	typedef enum logic {
		FUNC_ABSORB = 1'b0,
		FUNC_CLEAR  = 1'b1
	} func_code_t;

	// request passed from front to back
	typedef struct packed {
		logic        clear;
		logic [63:0] word;
	} wpc_req_t;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'd0,
		ST_ROUND = 2'd1,
		ST_EMIT  = 2'd2
	} back_state_t;

	// whirlpool s-box
	localparam logic [7:0] SBOX [256] = '{
		8'h18,8'h23,8'hc6,8'he8,8'h87,8'hb8,8'h01,8'h4f,8'h36,8'ha6,8'hd2,8'hf5,8'h79,8'h6f,8'h91,8'h52,
		8'h60,8'hbc,8'h9b,8'h8e,8'ha3,8'h0c,8'h7b,8'h35,8'h1d,8'he0,8'hd7,8'hc2,8'h2e,8'h4b,8'hfe,8'h57,
		8'h15,8'h77,8'h37,8'he5,8'h9f,8'hf0,8'h4a,8'hda,8'h58,8'hc9,8'h29,8'h0a,8'hb1,8'ha0,8'h6b,8'h85,
		8'hbd,8'h5d,8'h10,8'hf4,8'hcb,8'h3e,8'h05,8'h67,8'he4,8'h27,8'h41,8'h8b,8'ha7,8'h7d,8'h95,8'hd8,
		8'hfb,8'hee,8'h7c,8'h66,8'hdd,8'h17,8'h47,8'h9e,8'hca,8'h2d,8'hbf,8'h07,8'had,8'h5a,8'h83,8'h33,
		8'h63,8'h02,8'haa,8'h71,8'hc8,8'h19,8'h49,8'hd9,8'hf2,8'he3,8'h5b,8'h88,8'h9a,8'h26,8'h32,8'hb0,
		8'he9,8'h0f,8'hd5,8'h80,8'hbe,8'hcd,8'h34,8'h48,8'hff,8'h7a,8'h90,8'h5f,8'h20,8'h68,8'h1a,8'hae,
		8'hb4,8'h54,8'h93,8'h22,8'h64,8'hf1,8'h73,8'h12,8'h40,8'h08,8'hc3,8'hec,8'hdb,8'ha1,8'h8d,8'h3d,
		8'h97,8'h00,8'hcf,8'h2b,8'h76,8'h82,8'hd6,8'h1b,8'hb5,8'haf,8'h6a,8'h50,8'h45,8'hf3,8'h30,8'hef,
		8'h3f,8'h55,8'ha2,8'hea,8'h65,8'hba,8'h2f,8'hc0,8'hde,8'h1c,8'hfd,8'h4d,8'h92,8'h75,8'h06,8'h8a,
		8'hb2,8'he6,8'h0e,8'h1f,8'h62,8'hd4,8'ha8,8'h96,8'hf9,8'hc5,8'h25,8'h59,8'h84,8'h72,8'h39,8'h4c,
		8'h5e,8'h78,8'h38,8'h8c,8'hd1,8'ha5,8'he2,8'h61,8'hb3,8'h21,8'h9c,8'h1e,8'h43,8'hc7,8'hfc,8'h04,
		8'h51,8'h99,8'h6d,8'h0d,8'hfa,8'hdf,8'h7e,8'h24,8'h3b,8'hab,8'hce,8'h11,8'h8f,8'h4e,8'hb7,8'heb,
		8'h3c,8'h81,8'h94,8'hf7,8'hb9,8'h13,8'h2c,8'hd3,8'he7,8'h6e,8'hc4,8'h03,8'h56,8'h44,8'h7f,8'ha9,
		8'h2a,8'hbb,8'hc1,8'h53,8'hdc,8'h0b,8'h9d,8'h6c,8'h31,8'h74,8'hf6,8'h46,8'hac,8'h89,8'h14,8'he1,
		8'h16,8'h3a,8'h69,8'h09,8'h70,8'hb6,8'hd0,8'hed,8'hcc,8'h42,8'h98,8'ha4,8'h28,8'h5c,8'hf8,8'h86
	};

	// multiply by x modulo 0x11d
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1d : 8'h00);
	endfunction

	// s-box value times the mds row 1,1,4,1,8,5,2,9
	function automatic logic [63:0] lane_word(input logic [7:0] b);
		logic [7:0] s1, s2, s4, s8;
		s1 = SBOX[b];
		s2 = xtime(s1);
		s4 = xtime(s2);
		s8 = xtime(s4);
		lane_word = {s1, s1, s4, s1, s8, s4 ^ s1, s2, s8 ^ s1};
	endfunction

	// gamma, pi and theta on a 512-bit matrix of eight rows
	function automatic logic [WORDS*64-1:0] mix(input logic [WORDS*64-1:0] src);
		logic [WORDS*64-1:0] res;
		logic [63:0] acc, v, w;
		res = '0;
		for (int i = 0; i < WORDS; i++) begin
			acc = '0;
			for (int t = 0; t < WORDS; t++) begin
				v = src[((i + 8 - t) & 7)*64 +: 64];
				w = lane_word(v[(56 - 8*t) +: 8]);
				acc ^= (w >> (8*t)) | ((t == 0) ? 64'd0 : (w << (64 - 8*t)));
			end
			res[i*64 +: 64] = acc;
		end
		mix = res;
	endfunction

	// round constant for round r
	function automatic logic [63:0] round_const(input logic [3:0] r);
		logic [63:0] c;
		logic [7:0] base;
		c = '0;
		base = {1'b0, r, 3'b000};
		for (int j = 0; j < 8; j++)
			c = {c[55:0], SBOX[base + 8'(j)]};
		round_const = c;
	endfunction

endpackage

FILE: rtl/wpc_front.sv
module wpc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  logic             func,
	input  logic [63:0]      msg_word,
	output logic             req_valid,
	input  logic             req_ready,
	output wpc_pkg::wpc_req_t req
);

	wpc_pkg::wpc_req_t fifo_q [wpc_pkg::QDEPTH];
	logic [0:0] wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	// classify and queue requests
	assign ready     = (cnt_q != 2'(wpc_pkg::QDEPTH));
	assign push      = valid && ready;
	assign req_valid = (cnt_q != 2'd0);
	assign pop       = req_valid && req_ready;
	assign req       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].clear <= (func == wpc_pkg::FUNC_CLEAR);
			fifo_q[wr_ptr_q].word  <= msg_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/wpc_back.sv
module wpc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  wpc_pkg::wpc_req_t req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       hash_word,
	output logic [2:0]        word_index,
	output logic              last
);

	localparam int W = wpc_pkg::WORDS * 64;

	wpc_pkg::back_state_t state_q, state_d;
	logic [W-1:0] chain_q, buf_q, key_q, cst_q;
	logic [2:0]   cnt_q;
	logic [3:0]   round_q;
	logic [2:0]   emit_q;
	logic [W-1:0] key_next, cst_next, key_mix;
	logic         take;

	// one round per cycle on key and state
	always_comb begin
		key_mix  = wpc_pkg::mix(key_q);
		key_next = key_mix;
		key_next[63:0] = key_mix[63:0] ^ wpc_pkg::round_const(round_q);
		cst_next = wpc_pkg::mix(cst_q) ^ key_next;
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			wpc_pkg::ST_LOAD: begin
				req_ready = 1'b1;
				if (req_valid && !req.clear && cnt_q == 3'd7)
					state_d = wpc_pkg::ST_ROUND;
			end
			wpc_pkg::ST_ROUND: begin
				if (round_q == 4'(wpc_pkg::ROUNDS - 1))
					state_d = wpc_pkg::ST_EMIT;
			end
			wpc_pkg::ST_EMIT: begin
				if (out_ready && emit_q == 3'd7)
					state_d = wpc_pkg::ST_LOAD;
			end
			default: state_d = wpc_pkg::ST_LOAD;
		endcase
	end

	assign take       = req_valid && req_ready;
	assign out_valid  = (state_q == wpc_pkg::ST_EMIT);
	assign hash_word  = chain_q[emit_q*64 +: 64];
	assign word_index = emit_q;
	assign last       = (emit_q == 3'd7);

	// datapath registers
	always_ff @(posedge clk) begin
		if (take && !req.clear) begin
			buf_q[cnt_q*64 +: 64] <= req.word;
			if (cnt_q == 3'd7) begin
				key_q <= chain_q;
				cst_q <= {req.word, buf_q[W-65:0]} ^ chain_q;
			end
		end
		if (state_q == wpc_pkg::ST_ROUND) begin
			key_q <= key_next;
			cst_q <= cst_next;
		end
	end

	// control and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpc_pkg::ST_LOAD;
			cnt_q   <= '0;
			round_q <= '0;
			emit_q  <= '0;
			chain_q <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if (req.clear) begin
					chain_q <= '0;
					cnt_q   <= '0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (state_q == wpc_pkg::ST_ROUND) begin
				if (round_q == 4'(wpc_pkg::ROUNDS - 1)) begin
					round_q <= '0;
					chain_q <= chain_q ^ cst_next ^ buf_q;
				end else begin
					round_q <= round_q + 4'd1;
				end
			end
			if (out_valid && out_ready)
				emit_q <= emit_q + 3'd1;
		end
	end

endmodule

FILE: rtl/whirlpool_compression_unit.sv
// whirlpool compression unit
// input channel (valid/ready): func and msg_word; func 0 absorbs one 64-bit
// big-endian message word, func 1 clears the chaining value and drops any
// partly loaded block. the caller supplies whole 64-byte blocks.
// a two-entry request queue in front lets input be taken while the back end
// runs rounds or emits results.
// after the eighth word the back end runs ten rounds, one per cycle, with
// the key schedule and the state round computed side by side, then emits
// eight results (hash_word, word_index 0..7, last on index 7) on the output.
// the back end loads, runs rounds and emits in turn, and takes no new words
// until the last result is taken; results leave through the single emit
// port, one word per accepted transfer.
// reset clears the chaining value to zero and the word count.
// if the receiver stalls, the current result holds and the queue fills,
// then input ready drops.
module whirlpool_compression_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        func,
	input  logic [63:0] msg_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_word,
	output logic [2:0]  word_index,
	output logic        last
);

	logic              req_valid, req_ready;
	wpc_pkg::wpc_req_t req;

	wpc_front u_front (
		.clk, .arst_n, .valid, .ready, .func, .msg_word,
		.req_valid, .req_ready, .req
	);

	wpc_back u_back (
		.clk, .arst_n, .req_valid, .req_ready, .req,
		.out_valid, .out_ready, .hash_word, .word_index, .last
	);

`ifndef ASSERT_OFF
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (word_index == 3'd7)))
		else $error("last flag mismatch");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> (out_valid &&
		word_index == $past(word_index) + 3'd1))
		else $error("result index did not advance");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(hash_word))
		else $error("result changed under stall");
`endif

endmodule
